// ===== hdl/plc_pkg.sv =====
// ----------------------------------------------------------------------------
// plc_pkg - policy hill climbing agent shared definitions
// Widths, reset values, register map, sequencer states and small helpers.
// ----------------------------------------------------------------------------
package plc_pkg;

    localparam int NUM_ACTIONS_DEF = 3;
    localparam int NUM_STATES_DEF  = 9;

    localparam int PROB_W     = 17;
    localparam int Q_W        = 32;
    localparam int ACT_W      = 2;
    localparam int ST_W       = 4;
    localparam int DRAW_W     = 16;
    localparam int REW_W      = 16;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 4;
    localparam int FRAC       = 16;

    localparam int MUL_A_W = 18;
    localparam int MUL_B_W = 34;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam logic [PROB_W-1:0] ONE_Q16 = PROB_W'(65536);
    localparam logic [Q_W-1:0]    Q_RESET = Q_W'(6554);

    localparam logic [PROB_W-1:0] ALPHA_RST = PROB_W'(6554);
    localparam logic [PROB_W-1:0] DELTA_RST = PROB_W'(655);
    localparam logic [PROB_W-1:0] GAMMA_RST = PROB_W'(58982);
    localparam logic [PROB_W-1:0] EPS_RST   = PROB_W'(6554);

    typedef enum logic [1:0] {
        REG_LEARNING_RATE = 2'd0,
        REG_POLICY_STEP   = 2'd1,
        REG_DISCOUNT      = 2'd2,
        REG_EXPLORE_RATE  = 2'd3
    } t_reg_idx;

    typedef enum logic [4:0] {
        S_IDLE,
        S_QN_A,
        S_QN_D,
        S_QO_A,
        S_QO_D,
        S_MUL_G,
        S_MUL_K,
        S_MUL_A,
        S_Q_WR,
        S_BEST_A,
        S_BEST_D,
        S_P_A,
        S_P_D,
        S_ADJ,
        S_SUM,
        S_DIV_GO,
        S_DIV_W,
        S_MOVE,
        S_OUT_A,
        S_OUT_D,
        S_PICK,
        S_DONE
    } t_state;

    typedef enum logic {
        OP_ACT     = 1'b0,
        OP_OBSERVE = 1'b1
    } t_op;

    function automatic logic [PROB_W-1:0] cap_one(input logic [PROB_W-1:0] v);
        return (v > ONE_Q16) ? ONE_Q16 : v;
    endfunction

    // reduces a small value modulo m by repeated subtraction (v < 5*m)
    function automatic logic [4:0] mod_small(input logic [4:0] v, input logic [4:0] m);
        logic [4:0] r;
        r = v;
        for (int k = 0; k < 4; k++) begin
            if (r >= m) begin
                r = r - m;
            end
        end
        return r;
    endfunction

endpackage

// ===== hdl/policy_hill_climbing_agent.sv =====
// ----------------------------------------------------------------------------
// policy_hill_climbing_agent - Q-learning agent with hill climbing mixed policy
// Sequencer over Q and policy tables, one shared multiplier and a divider.
// ----------------------------------------------------------------------------
// Usage: one transaction in, one transaction out. The input channel carries
// an act (pick an action from the current state's policy, or explore) or an
// observe (Q update, policy step, renormalise, move to the next state).
// o_in_stall is high from acceptance until the result has been loaded into
// the output register; the next transaction may then be taken while the
// result still waits on a stalled output.
// Act: the policy row is read, an address and a data step per entry, then
// the action is picked and the result loaded.
// Observe: next-state Q row and own Q read, multiplier steps and the Q write,
// own Q row and policy row read, own entry adjusted, row summed, then each
// entry divided (17 quotient bits), or set uniform when the clipped row is
// empty; the state moves and the new row is read out. One read port a table.
// Reset: tables read as Q = 0.1 and uniform policy, state and action zero,
// registers at their defaults. No clearing pass: valid bits cover the tables.
// A stalled output holds its transaction; the sequencer waits in its final
// step until the output register is free.
// Registers via APB at byte addresses 0, 4, 8, 12; pready is always high.
// ----------------------------------------------------------------------------
module policy_hill_climbing_agent #(
    parameter int NUM_ACTIONS = plc_pkg::NUM_ACTIONS_DEF,
    parameter int NUM_STATES  = plc_pkg::NUM_STATES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [plc_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [plc_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [plc_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_operation,
    input  logic [plc_pkg::DRAW_W-1:0]         i_explore_draw,
    input  logic [plc_pkg::DRAW_W-1:0]         i_choice_draw,
    input  logic [plc_pkg::ACT_W-1:0]          i_random_action,
    input  logic signed [plc_pkg::REW_W-1:0]   i_reward,
    input  logic [plc_pkg::ACT_W-1:0]          i_opponent_action,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [plc_pkg::ACT_W-1:0]          o_chosen_action,
    output logic [plc_pkg::PROB_W-1:0]         o_prob_first,
    output logic [plc_pkg::PROB_W-1:0]         o_prob_second,
    output logic [plc_pkg::PROB_W-1:0]         o_prob_third,
    output logic [plc_pkg::ST_W-1:0]           o_state_index
);

    localparam int CELLS  = NUM_STATES * NUM_ACTIONS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(NUM_ACTIONS);
    localparam int SUM_W  = plc_pkg::PROB_W + $clog2(NUM_ACTIONS);
    localparam int PAD_N  = (NUM_ACTIONS > 3) ? NUM_ACTIONS : 3;
    localparam int DEC_SH = 19;
    localparam int NQ_W   = plc_pkg::PROD_W - plc_pkg::FRAC;

    localparam logic [CNT_W-1:0]  LAST_A  = CNT_W'(NUM_ACTIONS - 1);
    localparam logic [ADDR_W-1:0] NA_A    = ADDR_W'(NUM_ACTIONS);
    localparam logic [4:0]        NA_M    = 5'(NUM_ACTIONS);
    localparam logic [4:0]        NS_M    = 5'(NUM_STATES);
    localparam logic [plc_pkg::PROB_W-1:0] UNIFORM = plc_pkg::PROB_W'(65536 / NUM_ACTIONS);
    localparam logic [plc_pkg::MUL_B_W-1:0] DEC_RECIP =
        plc_pkg::MUL_B_W'((2**DEC_SH + NUM_ACTIONS - 2) / (NUM_ACTIONS - 1));
    localparam logic signed [NQ_W-1:0] NQ_MAX = NQ_W'(64'sd2147483647);
    localparam logic signed [NQ_W-1:0] NQ_MIN = NQ_W'(-64'sd2147483648);

    // configuration
    logic [plc_pkg::PROB_W-1:0] r_alpha, r_delta, r_gamma, r_eps;
    plc_pkg::t_reg_idx          w_ridx;
    logic                       w_cfg_wr;

    // sequencer
    plc_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt;
    logic             w_accept;
    logic             w_out_free;

    // agent state and latched transaction
    logic [plc_pkg::ST_W-1:0]   r_st, r_next;
    logic [plc_pkg::ACT_W-1:0]  r_act;
    logic                       r_op;
    logic [plc_pkg::DRAW_W-1:0] r_edraw, r_cdraw;
    logic [plc_pkg::ACT_W-1:0]  r_ract;
    logic signed [plc_pkg::REW_W-1:0] r_rew;

    // datapath
    logic signed [plc_pkg::Q_W-1:0]     r_qmax, r_q, r_qbest;
    logic signed [plc_pkg::MUL_B_W-1:0] r_tgt;
    logic signed [plc_pkg::PROD_W-1:0]  r_acc;
    logic [plc_pkg::PROB_W-1:0]         r_dec;
    logic [CNT_W-1:0]                   r_best;
    logic [plc_pkg::PROB_W-1:0]         r_prow [NUM_ACTIONS];
    logic [SUM_W-1:0]                   r_sum;

    // output register
    logic                       r_out_valid;
    logic [plc_pkg::ACT_W-1:0]  r_o_act;
    logic [plc_pkg::PROB_W-1:0] r_o_p0, r_o_p1, r_o_p2;
    logic [plc_pkg::ST_W-1:0]   r_o_st;

    // shared units and tables
    logic                               w_q_we, w_p_we;
    logic [ADDR_W-1:0]                  w_q_raddr, w_p_raddr, w_p_waddr;
    logic [plc_pkg::Q_W-1:0]            w_q_rdata, w_q_wdata;
    logic [plc_pkg::PROB_W-1:0]         w_p_rdata, w_p_wdata;
    logic signed [plc_pkg::MUL_A_W-1:0] w_mul_a;
    logic signed [plc_pkg::MUL_B_W-1:0] w_mul_b;
    logic signed [plc_pkg::PROD_W-1:0]  w_prod;
    logic                               w_div_start, w_div_done;
    logic [plc_pkg::PROB_W-1:0]         w_div_quot;

    // combinational helpers
    logic [ADDR_W-1:0]                  w_base, w_nbase, w_own_addr;
    logic [CNT_W-1:0]                   w_own;
    logic signed [plc_pkg::Q_W-1:0]     w_qrd;
    logic signed [plc_pkg::MUL_B_W-1:0] w_tgt;
    logic signed [plc_pkg::PROD_W-1:0]  w_nsum;
    logic signed [NQ_W-1:0]             w_nq_full;
    logic signed [plc_pkg::Q_W-1:0]     w_nq;
    logic [plc_pkg::PROB_W:0]           w_pup;
    logic [plc_pkg::PROB_W-1:0]         w_padj, w_pown;
    logic [SUM_W-1:0]                   w_sum, w_cum;
    logic [plc_pkg::ACT_W-1:0]          w_pick, w_ract_m, w_opp_m;
    logic [4:0]                         w_next_full;
    logic                               w_found;
    logic [plc_pkg::PROB_W-1:0]         w_pad [PAD_N];

    // ---------------- configuration port ----------------
    assign pready   = 1'b1;
    assign w_ridx   = plc_pkg::t_reg_idx'(paddr[3:2]);
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= plc_pkg::ALPHA_RST;
            r_delta <= plc_pkg::DELTA_RST;
            r_gamma <= plc_pkg::GAMMA_RST;
            r_eps   <= plc_pkg::EPS_RST;
        end else if (w_cfg_wr) begin
            unique case (w_ridx)
                plc_pkg::REG_LEARNING_RATE: r_alpha <= pwdata[plc_pkg::PROB_W-1:0];
                plc_pkg::REG_POLICY_STEP:   r_delta <= pwdata[plc_pkg::PROB_W-1:0];
                plc_pkg::REG_DISCOUNT:      r_gamma <= pwdata[plc_pkg::PROB_W-1:0];
                plc_pkg::REG_EXPLORE_RATE:  r_eps   <= pwdata[plc_pkg::PROB_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_ridx)
            plc_pkg::REG_LEARNING_RATE: prdata = plc_pkg::CFG_DATA_W'(r_alpha);
            plc_pkg::REG_POLICY_STEP:   prdata = plc_pkg::CFG_DATA_W'(r_delta);
            plc_pkg::REG_DISCOUNT:      prdata = plc_pkg::CFG_DATA_W'(r_gamma);
            plc_pkg::REG_EXPLORE_RATE:  prdata = plc_pkg::CFG_DATA_W'(r_eps);
            default:                    prdata = '0;
        endcase
    end

    // ---------------- shared units ----------------
    plc_ram #(
        .W       (plc_pkg::Q_W),
        .DEPTH   (CELLS),
        .RST_VAL (plc_pkg::Q_RESET)
    ) u_q_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_q_we),
        .i_waddr (w_own_addr),
        .i_wdata (w_q_wdata),
        .i_raddr (w_q_raddr),
        .o_rdata (w_q_rdata)
    );

    plc_ram #(
        .W       (plc_pkg::PROB_W),
        .DEPTH   (CELLS),
        .RST_VAL (UNIFORM)
    ) u_p_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_p_we),
        .i_waddr (w_p_waddr),
        .i_wdata (w_p_wdata),
        .i_raddr (w_p_raddr),
        .o_rdata (w_p_rdata)
    );

    plc_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    plc_div #(
        .DEN_W (SUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_prow[r_cnt]),
        .i_den   (r_sum),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    // ---------------- datapath helpers ----------------
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_base     = ADDR_W'(r_st) * NA_A;
    assign w_nbase    = ADDR_W'(r_next) * NA_A;
    assign w_own      = r_act[CNT_W-1:0];
    assign w_own_addr = w_base + ADDR_W'(w_own);
    assign w_p_waddr  = w_base + ADDR_W'(r_cnt);
    assign w_qrd      = $signed(w_q_rdata);

    assign w_ract_m    = plc_pkg::ACT_W'(plc_pkg::mod_small(5'(i_random_action), NA_M));
    assign w_opp_m     = plc_pkg::ACT_W'(plc_pkg::mod_small(5'(i_opponent_action), NA_M));
    assign w_next_full = plc_pkg::mod_small(5'(r_act) * NA_M + 5'(w_opp_m), NS_M);

    assign w_tgt = plc_pkg::MUL_B_W'(w_prod >>> plc_pkg::FRAC)
                 + (plc_pkg::MUL_B_W'(r_rew) <<< 8);

    assign w_nsum    = r_acc + w_prod;
    assign w_nq_full = NQ_W'(w_nsum >>> plc_pkg::FRAC);
    always_comb begin
        if (w_nq_full > NQ_MAX) begin
            w_nq = plc_pkg::Q_W'(NQ_MAX);
        end else if (w_nq_full < NQ_MIN) begin
            w_nq = plc_pkg::Q_W'(NQ_MIN);
        end else begin
            w_nq = plc_pkg::Q_W'(w_nq_full);
        end
    end
    assign w_q_wdata = w_nq;

    // policy step on the own action, clipped to 0..1
    assign w_pown = r_prow[w_own];
    assign w_pup  = {1'b0, w_pown} + {1'b0, plc_pkg::cap_one(r_delta)};
    always_comb begin
        if (r_best == w_own) begin
            w_padj = (w_pup > {1'b0, plc_pkg::ONE_Q16}) ? plc_pkg::ONE_Q16
                                                         : plc_pkg::PROB_W'(w_pup);
        end else begin
            w_padj = (w_pown < r_dec) ? '0 : (w_pown - r_dec);
        end
    end

    always_comb begin
        w_sum = '0;
        for (int a = 0; a < NUM_ACTIONS; a++) begin
            w_sum = w_sum + SUM_W'(r_prow[a]);
        end
    end

    // action choice: explore, else sample the row (draw on a boundary goes up)
    always_comb begin
        w_cum   = '0;
        w_found = 1'b0;
        w_pick  = plc_pkg::ACT_W'(NUM_ACTIONS - 1);
        if ({1'b0, r_edraw} < plc_pkg::cap_one(r_eps)) begin
            w_pick = r_ract;
        end else begin
            for (int a = 0; a < NUM_ACTIONS - 1; a++) begin
                w_cum = w_cum + SUM_W'(r_prow[a]);
                if (!w_found && (SUM_W'(r_cdraw) < w_cum)) begin
                    w_pick  = plc_pkg::ACT_W'(a);
                    w_found = 1'b1;
                end
            end
        end
    end

    always_comb begin
        for (int j = 0; j < PAD_N; j++) begin
            w_pad[j] = '0;
        end
        for (int j = 0; j < NUM_ACTIONS; j++) begin
            w_pad[j] = r_prow[j];
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= plc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_stall  = 1'b1;
        w_q_we      = 1'b0;
        w_q_raddr   = w_nbase + ADDR_W'(r_cnt);
        w_p_we      = 1'b0;
        w_p_wdata   = w_div_quot;
        w_p_raddr   = w_base + ADDR_W'(r_cnt);
        w_mul_a     = '0;
        w_mul_b     = '0;
        w_div_start = 1'b0;
        unique case (r_state)
            plc_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_state = (i_operation == plc_pkg::OP_OBSERVE) ? plc_pkg::S_QN_A
                                                                   : plc_pkg::S_OUT_A;
                end
            end
            plc_pkg::S_QN_A: n_state = plc_pkg::S_QN_D;
            plc_pkg::S_QN_D: n_state = (r_cnt == LAST_A) ? plc_pkg::S_QO_A : plc_pkg::S_QN_A;
            plc_pkg::S_QO_A: begin
                w_q_raddr = w_own_addr;
                n_state   = plc_pkg::S_QO_D;
            end
            plc_pkg::S_QO_D: n_state = plc_pkg::S_MUL_G;
            plc_pkg::S_MUL_G: begin
                w_mul_a = $signed({1'b0, plc_pkg::cap_one(r_gamma)});
                w_mul_b = plc_pkg::MUL_B_W'(r_qmax);
                n_state = plc_pkg::S_MUL_K;
            end
            plc_pkg::S_MUL_K: begin
                w_mul_a = $signed({1'b0, plc_pkg::ONE_Q16 - plc_pkg::cap_one(r_alpha)});
                w_mul_b = plc_pkg::MUL_B_W'(r_q);
                n_state = plc_pkg::S_MUL_A;
            end
            plc_pkg::S_MUL_A: begin
                w_mul_a = $signed({1'b0, plc_pkg::cap_one(r_alpha)});
                w_mul_b = r_tgt;
                n_state = plc_pkg::S_Q_WR;
            end
            plc_pkg::S_Q_WR: begin
                w_q_we  = 1'b1;
                w_mul_a = $signed({1'b0, plc_pkg::cap_one(r_delta)});
                w_mul_b = $signed(DEC_RECIP);
                n_state = plc_pkg::S_BEST_A;
            end
            plc_pkg::S_BEST_A: begin
                w_q_raddr = w_base + ADDR_W'(r_cnt);
                n_state   = plc_pkg::S_BEST_D;
            end
            plc_pkg::S_BEST_D: n_state = (r_cnt == LAST_A) ? plc_pkg::S_P_A : plc_pkg::S_BEST_A;
            plc_pkg::S_P_A:    n_state = plc_pkg::S_P_D;
            plc_pkg::S_P_D:    n_state = (r_cnt == LAST_A) ? plc_pkg::S_ADJ : plc_pkg::S_P_A;
            plc_pkg::S_ADJ:    n_state = plc_pkg::S_SUM;
            plc_pkg::S_SUM:    n_state = plc_pkg::S_DIV_GO;
            plc_pkg::S_DIV_GO: begin
                if (r_sum == '0) begin
                    w_p_we    = 1'b1;
                    w_p_wdata = UNIFORM;
                    if (r_cnt == LAST_A) begin
                        n_state = plc_pkg::S_MOVE;
                    end
                end else begin
                    w_div_start = 1'b1;
                    n_state     = plc_pkg::S_DIV_W;
                end
            end
            plc_pkg::S_DIV_W: begin
                if (w_div_done) begin
                    w_p_we  = 1'b1;
                    n_state = (r_cnt == LAST_A) ? plc_pkg::S_MOVE : plc_pkg::S_DIV_GO;
                end
            end
            plc_pkg::S_MOVE:  n_state = plc_pkg::S_OUT_A;
            plc_pkg::S_OUT_A: n_state = plc_pkg::S_OUT_D;
            plc_pkg::S_OUT_D: begin
                if (r_cnt == LAST_A) begin
                    n_state = (r_op == plc_pkg::OP_OBSERVE) ? plc_pkg::S_DONE
                                                            : plc_pkg::S_PICK;
                end else begin
                    n_state = plc_pkg::S_OUT_A;
                end
            end
            plc_pkg::S_PICK: n_state = plc_pkg::S_DONE;
            plc_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = plc_pkg::S_IDLE;
                end
            end
            default: n_state = plc_pkg::S_IDLE;
        endcase
    end

    // loop counter and agent state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_st  <= '0;
            r_act <= '0;
        end else begin
            case (r_state) inside
                plc_pkg::S_IDLE: r_cnt <= '0;
                plc_pkg::S_QN_D, plc_pkg::S_BEST_D, plc_pkg::S_P_D, plc_pkg::S_OUT_D: begin
                    r_cnt <= (r_cnt == LAST_A) ? '0 : r_cnt + CNT_W'(1);
                end
                plc_pkg::S_DIV_GO: begin
                    if (r_sum == '0) begin
                        r_cnt <= (r_cnt == LAST_A) ? '0 : r_cnt + CNT_W'(1);
                    end
                end
                plc_pkg::S_DIV_W: begin
                    if (w_div_done) begin
                        r_cnt <= (r_cnt == LAST_A) ? '0 : r_cnt + CNT_W'(1);
                    end
                end
                plc_pkg::S_MOVE: r_st  <= r_next;
                plc_pkg::S_PICK: r_act <= w_pick;
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= i_operation;
            r_edraw <= i_explore_draw;
            r_cdraw <= i_choice_draw;
            r_ract  <= w_ract_m;
            r_rew   <= i_reward;
            r_next  <= plc_pkg::ST_W'(w_next_full);
        end
        case (r_state) inside
            plc_pkg::S_QN_D: begin
                if (r_cnt == '0 || w_qrd > r_qmax) begin
                    r_qmax <= w_qrd;
                end
            end
            plc_pkg::S_QO_D:  r_q   <= w_qrd;
            plc_pkg::S_MUL_A: r_acc <= w_prod;
            plc_pkg::S_MUL_K: r_tgt <= w_tgt;
            plc_pkg::S_BEST_A: begin
                if (r_cnt == '0) begin
                    r_dec <= plc_pkg::PROB_W'(w_prod >>> DEC_SH);
                end
            end
            plc_pkg::S_BEST_D: begin
                if (r_cnt == '0 || w_qrd > r_qbest) begin
                    r_qbest <= w_qrd;
                    r_best  <= r_cnt;
                end
            end
            plc_pkg::S_P_D, plc_pkg::S_OUT_D: r_prow[r_cnt] <= w_p_rdata;
            plc_pkg::S_ADJ: r_prow[w_own] <= w_padj;
            plc_pkg::S_SUM: r_sum <= w_sum;
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == plc_pkg::S_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == plc_pkg::S_DONE && w_out_free) begin
            r_o_act <= r_act;
            r_o_p0  <= w_pad[0];
            r_o_p1  <= w_pad[1];
            r_o_p2  <= w_pad[2];
            r_o_st  <= r_st;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_chosen_action = r_o_act;
    assign o_prob_first    = r_o_p0;
    assign o_prob_second   = r_o_p1;
    assign o_prob_third    = r_o_p2;
    assign o_state_index   = r_o_st;

endmodule

// ===== hdl/plc_ram.sv =====
// ----------------------------------------------------------------------------
// plc_ram - single write, single registered read table with valid bits
// Entries never written read back as the reset value.
// ----------------------------------------------------------------------------
module plc_ram #(
    parameter int             W       = 32,
    parameter int             DEPTH   = 27,
    parameter logic [W-1:0]   RST_VAL = '0
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);

    logic [W-1:0]     r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [W-1:0]     r_rdata;
    logic             r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_rvld <= r_vld[i_raddr];
        end
    end

    assign o_rdata = r_rvld ? r_rdata : RST_VAL;

endmodule

// ===== hdl/plc_mul.sv =====
// ----------------------------------------------------------------------------
// plc_mul - shared signed multiplier
// One product per cycle, registered at the output.
// ----------------------------------------------------------------------------
module plc_mul (
    input  logic                               i_clk,
    input  logic signed [plc_pkg::MUL_A_W-1:0] i_a,
    input  logic signed [plc_pkg::MUL_B_W-1:0] i_b,
    output logic signed [plc_pkg::PROD_W-1:0]  o_prod
);

    logic signed [plc_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= plc_pkg::PROD_W'(i_a) * plc_pkg::PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

// ===== hdl/plc_div.sv =====
// ----------------------------------------------------------------------------
// plc_div - radix-2 restoring divider for row renormalisation
// Computes floor(num * 65536 / den) for num <= den, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module plc_div #(
    parameter int DEN_W = 19
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [plc_pkg::PROB_W-1:0]  i_num,
    input  logic [DEN_W-1:0]            i_den,
    output logic                        o_done,
    output logic [plc_pkg::PROB_W-1:0]  o_quot
);

    localparam int STEPS = plc_pkg::PROB_W;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [DEN_W-1:0]           r_rem;
    logic [plc_pkg::PROB_W-1:0] r_bits;
    logic [plc_pkg::PROB_W-1:0] r_quot;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_done;
    logic [DEN_W:0]             w_trial;
    logic                       w_fit;

    assign w_trial = {r_rem, r_bits[plc_pkg::PROB_W-1]};
    assign w_fit   = (w_trial >= {1'b0, i_den});

    // the top 16 bits of num<<16 always give zero quotient bits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= DEN_W'(i_num >> 1);
            r_bits <= {i_num[0], (plc_pkg::PROB_W-1)'(0)};
        end else if (r_cnt != '0) begin
            r_rem  <= w_fit ? DEN_W'(w_trial - {1'b0, i_den}) : DEN_W'(w_trial);
            r_bits <= r_bits << 1;
            r_quot <= {r_quot[plc_pkg::PROB_W-2:0], w_fit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= CNT_W'(STEPS);
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CNT_W'(1));
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== tb/plc_agent_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// plc_agent_checker - result scoreboard for the policy hill climbing agent
// Watches the register port and both transaction channels. Keeps its own
// Q table, policy table, state, action and rate registers, predicts the
// result of every accepted transaction and compares each field in order.
// ----------------------------------------------------------------------------
module plc_agent_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_psel,
    input  logic                               i_penable,
    input  logic                               i_pwrite,
    input  logic                               i_pready,
    input  logic [plc_pkg::CFG_ADDR_W-1:0]     i_paddr,
    input  logic [plc_pkg::CFG_DATA_W-1:0]     i_pwdata,
    input  logic                               i_in_valid,
    input  logic                               i_in_stall,
    input  logic                               i_operation,
    input  logic [plc_pkg::DRAW_W-1:0]         i_explore_draw,
    input  logic [plc_pkg::DRAW_W-1:0]         i_choice_draw,
    input  logic [plc_pkg::ACT_W-1:0]          i_random_action,
    input  logic signed [plc_pkg::REW_W-1:0]   i_reward,
    input  logic [plc_pkg::ACT_W-1:0]          i_opponent_action,
    input  logic                               i_out_valid,
    input  logic                               i_out_stall,
    input  logic [plc_pkg::ACT_W-1:0]          i_chosen_action,
    input  logic [plc_pkg::PROB_W-1:0]         i_prob_first,
    input  logic [plc_pkg::PROB_W-1:0]         i_prob_second,
    input  logic [plc_pkg::PROB_W-1:0]         i_prob_third,
    input  logic [plc_pkg::ST_W-1:0]           i_state_index,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    import plc_pkg::*;

    localparam int NA         = NUM_ACTIONS_DEF;
    localparam int NS         = NUM_STATES_DEF;
    localparam int CELLS      = NA * NS;
    localparam int MAX_PRINTS = 100;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [PROB_W-1:0] prob0;
        logic [PROB_W-1:0] prob1;
        logic [PROB_W-1:0] prob2;
        logic [ST_W-1:0]   state_idx;
    } agent_result_t;

    int                q_tab   [CELLS];
    logic [PROB_W-1:0] pol_tab [CELLS];
    int unsigned       cur_state;
    int unsigned       cur_act;
    logic [PROB_W-1:0] alpha_r, delta_r, gamma_r, eps_r;
    agent_result_t     result_q [$];

    function automatic longint clamp_unit(input logic [PROB_W-1:0] v);
        return (v > 65536) ? 65536 : longint'(v);
    endfunction

    task automatic agent_reset();
        for (int k = 0; k < CELLS; k++) begin
            q_tab[k]   = int'(Q_RESET);
            pol_tab[k] = PROB_W'(65536 / NA);
        end
        cur_state = 0;
        cur_act   = 0;
        alpha_r   = ALPHA_RST;
        delta_r   = DELTA_RST;
        gamma_r   = GAMMA_RST;
        eps_r     = EPS_RST;
        result_q.delete();
    endtask

    task automatic choose_action(input logic [DRAW_W-1:0] edraw, input logic [DRAW_W-1:0] cdraw,
                                 input logic [ACT_W-1:0] ract);
        int unsigned base;
        longint      acc;
        bit          found;
        base = cur_state * NA;
        if (edraw < clamp_unit(eps_r)) begin
            cur_act = ract % NA;
        end else begin
            acc     = 0;
            found   = 1'b0;
            cur_act = NA - 1;
            // a draw on a boundary falls to the higher action
            for (int a = 0; a < NA - 1; a++) begin
                acc += pol_tab[base + a];
                if (!found && cdraw < acc) begin
                    cur_act = a;
                    found   = 1'b1;
                end
            end
        end
    endtask

    task automatic learn_outcome(input logic signed [REW_W-1:0] rew,
                                 input logic [ACT_W-1:0] opp_in);
        int unsigned base, own, nxt, best;
        longint      alpha, gamma, delta, qv, qmax, target, nq, pv, total;
        base  = cur_state * NA;
        own   = cur_act % NA;
        nxt   = (NA * own + opp_in % NA) % NS;
        alpha = clamp_unit(alpha_r);
        gamma = clamp_unit(gamma_r);
        delta = clamp_unit(delta_r);
        qv    = q_tab[base + own];
        qmax  = q_tab[nxt * NA];
        for (int a = 1; a < NA; a++) begin
            if (q_tab[nxt * NA + a] > qmax) begin
                qmax = q_tab[nxt * NA + a];
            end
        end
        target = longint'(rew) * 256 + ((gamma * qmax) >>> 16);
        nq     = ((65536 - alpha) * qv + alpha * target) >>> 16;
        if (nq > longint'(32'sh7FFF_FFFF)) begin
            nq = longint'(32'sh7FFF_FFFF);
        end
        if (nq < longint'(32'sh8000_0000)) begin
            nq = longint'(32'sh8000_0000);
        end
        q_tab[base + own] = int'(nq);

        // greedy action of the updated row, first index wins ties
        best = 0;
        for (int a = 1; a < NA; a++) begin
            if (q_tab[base + a] > q_tab[base + best]) begin
                best = a;
            end
        end
        pv = pol_tab[base + own];
        if (best == own) begin
            pv += delta;
        end else begin
            pv -= delta / (NA - 1);
        end
        if (pv < 0) begin
            pv = 0;
        end
        if (pv > 65536) begin
            pv = 65536;
        end
        pol_tab[base + own] = PROB_W'(pv);

        total = 0;
        for (int a = 0; a < NA; a++) begin
            total += pol_tab[base + a];
        end
        for (int a = 0; a < NA; a++) begin
            if (total == 0) begin
                pol_tab[base + a] = PROB_W'(65536 / NA);
            end else begin
                pol_tab[base + a] = PROB_W'((longint'(pol_tab[base + a]) * 65536) / total);
            end
        end
        cur_state = nxt;
    endtask

    function automatic agent_result_t agent_view();
        agent_result_t r;
        r.action    = ACT_W'(cur_act);
        r.prob0     = pol_tab[cur_state * NA];
        r.prob1     = pol_tab[cur_state * NA + 1];
        r.prob2     = pol_tab[cur_state * NA + 2];
        r.state_idx = ST_W'(cur_state);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        o_fail_count++;
        if (o_fail_count <= MAX_PRINTS) begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0d expected %0d", what, got, want));
        end
    endtask

    initial begin
        o_fail_count = 0;
    end

    always @(posedge i_clk) begin : watch
        agent_result_t want;
        if (!i_rst_n) begin
            agent_reset();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[3:2]))
                    REG_LEARNING_RATE: alpha_r = i_pwdata[PROB_W-1:0];
                    REG_POLICY_STEP:   delta_r = i_pwdata[PROB_W-1:0];
                    REG_DISCOUNT:      gamma_r = i_pwdata[PROB_W-1:0];
                    REG_EXPLORE_RATE:  eps_r   = i_pwdata[PROB_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (result_q.size() == 0) begin
                    report_mismatch("result transaction with nothing outstanding");
                end else begin
                    want = result_q.pop_front();
                    check_field("chosen_action", 32'(i_chosen_action), 32'(want.action));
                    check_field("prob_first", 32'(i_prob_first), 32'(want.prob0));
                    check_field("prob_second", 32'(i_prob_second), 32'(want.prob1));
                    check_field("prob_third", 32'(i_prob_third), 32'(want.prob2));
                    check_field("state_index", 32'(i_state_index), 32'(want.state_idx));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (t_op'(i_operation) == OP_OBSERVE) begin
                    learn_outcome(i_reward, i_opponent_action);
                end else begin
                    choose_action(i_explore_draw, i_choice_draw, i_random_action);
                end
                result_q.push_back(agent_view());
            end
        end
        o_pending <= result_q.size();
    end

endmodule

// ===== tb/tb_policy_hill_climbing_agent.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_policy_hill_climbing_agent - regression for the hill climbing agent
// Directed act/observe transactions on sampling and explore boundaries, then
// phases of random play under extreme and random rate settings, with random
// gaps on both channels, one long output hold-off and one gap-free stretch.
// ----------------------------------------------------------------------------
module tb_policy_hill_climbing_agent;
    import plc_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 800_000;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          DRAIN_CYCLES = 150;
    localparam int          IDLE_PCT     = 18;

    typedef enum logic [1:0] {
        RX_RANDOM,
        RX_FREE,
        RX_HOLD
    } rx_mode_t;

    typedef enum logic [1:0] {
        RW_FULL,
        RW_HIGH,
        RW_LOW
    } reward_mix_t;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    psel, penable, pwrite;
    logic [CFG_ADDR_W-1:0]   paddr;
    logic [CFG_DATA_W-1:0]   pwdata;
    logic [CFG_DATA_W-1:0]   prdata;
    logic                    pready;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic                    i_operation;
    logic [DRAW_W-1:0]       i_explore_draw;
    logic [DRAW_W-1:0]       i_choice_draw;
    logic [ACT_W-1:0]        i_random_action;
    logic signed [REW_W-1:0] i_reward;
    logic [ACT_W-1:0]        i_opponent_action;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic [ACT_W-1:0]        o_chosen_action;
    logic [PROB_W-1:0]       o_prob_first, o_prob_second, o_prob_third;
    logic [ST_W-1:0]         o_state_index;

    int                      fail_count;
    int                      pending;
    int unsigned             cycles = 0;
    rx_mode_t                rx_mode = RX_RANDOM;
    bit                      hold_done = 1'b0;
    bit                      tx_idle_on = 1'b1;
    reward_mix_t             rew_mix = RW_FULL;
    logic [PROB_W-1:0]       cfg_val [4];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    policy_hill_climbing_agent dut (
        .i_clk, .i_rst_n,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .i_in_valid, .o_in_stall,
        .i_operation, .i_explore_draw, .i_choice_draw, .i_random_action,
        .i_reward, .i_opponent_action,
        .o_out_valid, .i_out_stall,
        .o_chosen_action, .o_prob_first, .o_prob_second, .o_prob_third,
        .o_state_index
    );

    plc_agent_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_psel            (psel),
        .i_penable         (penable),
        .i_pwrite          (pwrite),
        .i_pready          (pready),
        .i_paddr           (paddr),
        .i_pwdata          (pwdata),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_operation       (i_operation),
        .i_explore_draw    (i_explore_draw),
        .i_choice_draw     (i_choice_draw),
        .i_random_action   (i_random_action),
        .i_reward          (i_reward),
        .i_opponent_action (i_opponent_action),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_chosen_action   (o_chosen_action),
        .i_prob_first      (o_prob_first),
        .i_prob_second     (o_prob_second),
        .i_prob_third      (o_prob_third),
        .i_state_index     (o_state_index),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    // output side back-pressure; the long hold-off runs once
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_mode == RX_HOLD && !hold_done) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
                i_out_stall <= 1'b0;
            end else if (rx_mode == RX_FREE) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    task automatic send_item(input t_op op, input logic [DRAW_W-1:0] edraw,
                             input logic [DRAW_W-1:0] cdraw, input logic [ACT_W-1:0] ract,
                             input logic signed [REW_W-1:0] rew, input logic [ACT_W-1:0] opp);
        while (tx_idle_on && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_operation       <= op;
        i_explore_draw    <= edraw;
        i_choice_draw     <= cdraw;
        i_random_action   <= ract;
        i_reward          <= rew;
        i_opponent_action <= opp;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic play_act(input logic [DRAW_W-1:0] edraw, input logic [DRAW_W-1:0] cdraw,
                            input logic [ACT_W-1:0] ract);
        send_item(OP_ACT, edraw, cdraw, ract, REW_W'($urandom), ACT_W'($urandom));
    endtask

    task automatic play_observe(input logic signed [REW_W-1:0] rew,
                                input logic [ACT_W-1:0] opp);
        send_item(OP_OBSERVE, DRAW_W'($urandom), DRAW_W'($urandom), ACT_W'($urandom),
                  rew, opp);
    endtask

    function automatic logic signed [REW_W-1:0] pick_reward(input reward_mix_t mix);
        int r;
        r = $urandom_range(0, 99);
        if (mix == RW_HIGH && r < 90) begin
            return 16'sh7FFF;
        end
        if (mix == RW_LOW && r < 90) begin
            return 16'sh8000;
        end
        if (r < 30) begin
            return REW_W'(int'($urandom_range(0, 1023)) - 512);
        end
        return REW_W'($urandom);
    endfunction

    function automatic logic [PROB_W-1:0] pick_rate();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return PROB_W'(65536);
            2:       return PROB_W'(1);
            3:       return PROB_W'($urandom_range(65537, 131071));
            default: return PROB_W'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic random_act();
        logic [DRAW_W-1:0] edraw;
        if ($urandom_range(0, 9) == 0) begin
            // explore threshold and one below
            edraw = DRAW_W'(cfg_val[REG_EXPLORE_RATE] - $urandom_range(0, 1));
        end else begin
            edraw = DRAW_W'($urandom);
        end
        play_act(edraw, DRAW_W'($urandom), ACT_W'($urandom_range(0, 3)));
    endtask

    task automatic random_play(input int n);
        int sent;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(99) < 85) begin
                random_act();
                play_observe(pick_reward(rew_mix), ACT_W'($urandom_range(0, 3)));
                sent += 2;
            end else begin
                if ($urandom_range(0, 1) == 1) begin
                    random_act();
                end else begin
                    play_observe(pick_reward(rew_mix), ACT_W'($urandom_range(0, 3)));
                end
                sent += 1;
            end
        end
    endtask

    task automatic wait_results_done();
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [PROB_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= CFG_DATA_W'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_rates(input logic [PROB_W-1:0] lr, input logic [PROB_W-1:0] step,
                             input logic [PROB_W-1:0] disc, input logic [PROB_W-1:0] eps);
        cfg_val[REG_LEARNING_RATE] = lr;
        cfg_val[REG_POLICY_STEP]   = step;
        cfg_val[REG_DISCOUNT]      = disc;
        cfg_val[REG_EXPLORE_RATE]  = eps;
        for (int k = 0; k < 4; k++) begin
            write_reg(t_reg_idx'(k), cfg_val[k]);
        end
    endtask

    initial begin : stimulus
        i_rst_n           <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        i_in_valid        <= 1'b0;
        i_operation       <= OP_ACT;
        i_explore_draw    <= '0;
        i_choice_draw     <= '0;
        i_random_action   <= '0;
        i_reward          <= '0;
        i_opponent_action <= '0;
        cfg_val[REG_LEARNING_RATE] = ALPHA_RST;
        cfg_val[REG_POLICY_STEP]   = DELTA_RST;
        cfg_val[REG_DISCOUNT]      = GAMMA_RST;
        cfg_val[REG_EXPLORE_RATE]  = EPS_RST;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // uniform row: boundaries at 21845 and 43690, explore below 6554
        play_act(16'd6554, 16'd21845, 2'd0);
        play_act(16'hFFFF, 16'd21844, 2'd1);
        play_act(16'hFFFF, 16'd43690, 2'd0);
        play_act(16'hFFFF, 16'd43689, 2'd0);
        play_act(16'hFFFF, 16'hFFFF, 2'd1);
        play_act(16'hFFFF, 16'd0, 2'd2);
        play_act(16'd6553, 16'd0, 2'd3);
        play_act(16'd0, 16'hFFFF, 2'd2);
        play_observe(16'sh7FFF, 2'd3);
        play_act(16'd0, 16'd0, 2'd1);
        play_observe(16'sh8000, 2'd2);
        play_observe(16'sh0000, 2'd1);
        play_act(16'd0, 16'd0, 2'd0);
        play_observe(-16'sd1, 2'd0);
        play_act(16'd6554, 16'd21845, 2'd3);
        play_act(16'hFFFF, 16'd32768, 2'd3);
        play_observe(16'sh0100, 2'd1);
        play_act(16'd0, 16'h5555, 2'd2);
        play_observe(16'sh8001, 2'd2);
        play_act(16'd0, 16'hAAAA, 2'd3);
        play_observe(16'sh5555, 2'd0);
        play_observe(16'shAAAA, 2'd3);

        for (int ph = 0; ph < 10; ph++) begin
            i_in_valid <= 1'b0;
            wait_results_done();
            tx_idle_on = 1'b1;
            rew_mix    = RW_FULL;
            rx_mode   <= RX_RANDOM;
            case (ph)
                0: begin
                    set_rates(PROB_W'(65536), PROB_W'(65536), PROB_W'(65536), PROB_W'(65536));
                    rew_mix = RW_HIGH;
                end
                1: set_rates('0, '0, '0, '0);
                2: begin
                    set_rates('1, '1, '1, '1);
                    rew_mix = RW_LOW;
                end
                3: set_rates(PROB_W'(32768), PROB_W'(65535), PROB_W'(65536), PROB_W'(1));
                4: begin
                    set_rates(pick_rate(), pick_rate(), pick_rate(), pick_rate());
                    tx_idle_on = 1'b0;
                    rx_mode   <= RX_HOLD;
                end
                5: begin
                    set_rates(pick_rate(), pick_rate(), pick_rate(), pick_rate());
                    tx_idle_on = 1'b0;
                    rx_mode   <= RX_FREE;
                end
                default: set_rates(pick_rate(), pick_rate(), pick_rate(), pick_rate());
            endcase
            random_play(ph < 4 ? 110 : 200);
        end

        i_in_valid <= 1'b0;
        wait_results_done();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
